FILE: hdl/tdpt_pkg.sv
// Shared types for the trial-division prime test.
// Holds the sequencer state enum and the divider control/status structs.
// No dependencies.
package tdpt_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_DONE
    } tdpt_state_t;

    // Sequencer to divider
    typedef struct packed {
        logic start;
    } tdpt_div_req_t;

    // Divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } tdpt_div_sts_t;

endpackage

FILE: hdl/tdpt_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Gives quotient and remainder of an unsigned NW-bit division; uses tdpt_pkg.
module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int NW = 31
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tdpt_div_req_t req,
    output tdpt_div_sts_t sts,
    input  logic [NW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic [NW-1:0] remainder
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dvs_reg;

    logic [NW:0]   shifted;
    logic          take;
    logic [NW:0]   diff;

    // One restoring step: bring in the next dividend bit and try to subtract
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign take    = (shifted >= {1'b0, dvs_reg});
    assign diff    = shifted - {1'b0, dvs_reg};

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(NW);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], take};
            rem_reg <= take ? diff[NW-1:0] : shifted[NW-1:0];
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dvs_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: hdl/tdpt_seq.sv
// Sequencer for the trial-division prime test: input checks, divisor
// stepping, result register. Drives one tdpt_divider; uses tdpt_pkg.
module tdpt_seq
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] number,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             is_prime,
    output tdpt_div_req_t    div_req,
    input  tdpt_div_sts_t    div_sts,
    output logic [WIDTH-2:0] dividend,
    output logic [WIDTH-2:0] divisor,
    input  logic [WIDTH-2:0] quotient,
    input  logic [WIDTH-2:0] remainder
);

    localparam int NW = WIDTH - 1;

    tdpt_state_t   state_reg;
    tdpt_state_t   state_next;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] d_reg;
    logic          res_reg;
    logic          out_valid_reg;
    logic          out_bit_reg;

    logic          accept;
    logic          out_load;
    logic          neg;
    logic [NW-1:0] mag;
    logic          needs_search;
    logic          quick_res;
    logic          past_root;
    logic          stop;

    // Classify the incoming number
    assign neg          = number[WIDTH-1];
    assign mag          = number[NW-1:0];
    assign needs_search = !neg && mag[0] && (mag > NW'(1));
    assign quick_res    = !neg && (mag == NW'(2));
    assign accept       = in_valid && in_ready;

    // Trial outcome: divisor beyond the square root, or an exact divisor
    assign past_root = (d_reg > quotient);
    assign stop      = past_root || (remainder == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = needs_search ? ST_START : ST_DONE;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:  if (div_sts.done) state_next = stop ? ST_DONE : ST_START;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready      = 1'b0;
        div_req.start = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_START: div_req.start = 1'b1;
            ST_WAIT:  ;
            ST_DONE:  out_load = !out_valid_reg || out_ready;
            default:  ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg   <= mag;
            d_reg   <= NW'(3);
            res_reg <= quick_res;
        end
        else if (state_reg == ST_WAIT && div_sts.done)
        begin
            if (stop)
                res_reg <= past_root;
            else
                d_reg <= d_reg + NW'(2);
        end
        if (out_load)
            out_bit_reg <= res_reg;
    end

    assign dividend  = n_reg;
    assign divisor   = d_reg;
    assign out_valid = out_valid_reg;
    assign is_prime  = out_bit_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted twice in a row");

    a_odd_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) |-> (d_reg[0] && d_reg >= NW'(3)))
        else $error("trial divisor not odd or below three");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished test");
`endif

endmodule

FILE: hdl/trial_division_prime_test.sv
// Trial-division prime test, top level: stream ports and byte packing.
// Instantiates tdpt_seq and tdpt_divider; uses tdpt_pkg.
//
//  channel  dir  payload                          handshake
//  s_*      in   tdata[WIDTH-1:0] = number        s_tvalid / s_tready
//  m_*      out  tdata[0] = is_prime              m_tvalid / m_tready
//
// Negative, 0, 1, 2 and even numbers skip the divider. Odd numbers above 1
// run one division per odd trial divisor, counting up from 3, until the
// divisor passes sqrt(number) or divides the number exactly.
// rst_n is asynchronous, active low, and clears all control state.
// One request at a time; the next is taken while a result waits on m_tready.
module trial_division_prime_test
    import tdpt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((WIDTH+7)/8)*8-1:0]    s_tdata,   // [WIDTH-1:0] number
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata    // [0] is_prime
);

    localparam int NW = WIDTH - 1;

    tdpt_div_req_t div_req;
    tdpt_div_sts_t div_sts;
    logic [NW-1:0] dividend;
    logic [NW-1:0] divisor;
    logic [NW-1:0] quotient;
    logic [NW-1:0] remainder;
    logic          is_prime;

    tdpt_seq #(
        .WIDTH (WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .number    (s_tdata[WIDTH-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .is_prime  (is_prime),
        .div_req   (div_req),
        .div_sts   (div_sts),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (remainder)
    );

    tdpt_divider #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .sts       (div_sts),
        .dividend  (dividend),
        .divisor   (divisor),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Result byte, flag in bit 0
    assign m_tdata = {7'b0, is_prime};

endmodule
